@@ hw/rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // Input opcodes.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result event codes.
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_VALID    = 3'd1;
   localparam logic [2:0] EV_BAD_SUM  = 3'd2;
   localparam logic [2:0] EV_OWN_ECHO = 3'd3;
   localparam logic [2:0] EV_RUNT     = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_OWN_ADDRESS  = 2'd0;
   localparam logic [1:0] CSR_LINK_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_STARTUP_HOLD = 2'd2;

   // Configuration reset values.
   localparam logic [7:0]  OWN_ADDRESS_RESET  = 8'h20;
   localparam logic [15:0] LINK_TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] STARTUP_HOLD_RESET = 16'd1000;

   // Framing bytes and limits.
   localparam logic [7:0]  SYNC_FIRST   = 8'h55;
   localparam logic [7:0]  SYNC_SECOND  = 8'hAA;
   localparam logic [15:0] SUM_INVERT   = 16'hFFFF;
   localparam logic [15:0] COUNTER_MAX  = 16'hFFFF;
   localparam logic [7:0]  LENGTH_MAX   = 8'd255;

   // One classified word waiting in the queue between front and back.
   typedef struct packed {
      logic       is_tick;
      logic       is_second_sync;
      logic [7:0] rx_byte;
   } item_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

@@ hw/rtl/sfr_channels.sv @@
// ----------------------------------------------------------------------------
// sfr_channels
// Valid/ready channel interfaces of the serial frame receiver.
// ----------------------------------------------------------------------------
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;

   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  frame_length;
   logic [7:0]  address;
   logic [7:0]  command;
   logic [7:0]  argument;
   logic [15:0] received_checksum;
   logic        connected;

   modport source (output valid, output event_res, output frame_length, output address,
                   output command, output argument, output received_checksum,
                   output connected, input ready);
   modport sink   (input valid, input event_res, input frame_length, input address,
                   input command, input argument, input received_checksum,
                   input connected, output ready);
endinterface

interface sfr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/sfr_front.sv @@
// ----------------------------------------------------------------------------
// sfr_front
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sfr_front
   import sfr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   sfr_req_if.sink        req_chan,
   output queue_head_type head,
   input  logic           pop
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   new_item;

   // The queue takes a word whenever it has a free entry.
   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;

   // Classify the word on the way in.
   always_comb begin
      new_item.is_tick        = (req_chan.opcode == OP_TICK);
      new_item.is_second_sync = (req_chan.rx_byte == SYNC_SECOND);
      new_item.rx_byte        = req_chan.rx_byte;
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ hw/rtl/sfr_back.sv @@
// ----------------------------------------------------------------------------
// sfr_back
// Configuration registers, frame tracking, checksum test, link timers and the result register.
// ----------------------------------------------------------------------------
module sfr_back
   import sfr_pkg::*;
#(
   parameter int MAX_POSITION = 256
)
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   sfr_csr_if.sink        csr_chan,
   sfr_rsp_if.source      rsp_chan
);

   localparam int PW = $clog2(MAX_POSITION);
   localparam logic [PW-1:0] POS_LAST = PW'(MAX_POSITION - 1);

   // Configuration registers.
   logic [7:0]  own_address_ff;
   logic [15:0] link_timeout_ff;
   logic [15:0] startup_hold_ff;

   // Frame and link state.
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    recent_ff [3];
   logic [7:0]    recent_in [3];
   logic [7:0]    hdr_ff [3];
   logic [7:0]    hdr_in [3];
   logic [15:0]   sum_ff, sum_in;
   logic          ovf_ff, ovf_in;
   logic [15:0]   uptime_ff, uptime_in;
   logic [15:0]   since_ff, since_in;

   // Result register.
   logic          rsp_valid_ff;
   logic [2:0]    ev_ff, ev_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    addr_ff, addr_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    arg_ff, arg_in;
   logic [15:0]   rxsum_ff, rxsum_in;
   logic          conn_ff, conn_in;

   logic          close;
   logic [PW-1:0] flen;
   logic [16:0]   sum_ext;
   logic [15:0]   frame_sum;

   // A word is executed when the result register is free or being emptied.
   assign pop = head.valid && (!rsp_valid_ff || rsp_chan.ready);

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff  <= OWN_ADDRESS_RESET;
         link_timeout_ff <= LINK_TIMEOUT_RESET;
         startup_hold_ff <= STARTUP_HOLD_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_OWN_ADDRESS:  own_address_ff  <= csr_chan.data[7:0];
            CSR_LINK_TIMEOUT: link_timeout_ff <= csr_chan.data;
            CSR_STARTUP_HOLD: startup_hold_ff <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   assign close = !head.item.is_tick && (pos_ff != '0) && (recent_ff[0] == SYNC_FIRST)
                  && head.item.is_second_sync;
   assign flen      = pos_ff - PW'(1);
   assign sum_ext   = {1'b0, sum_ff} + {9'd0, recent_ff[2]};
   assign frame_sum = {recent_ff[1], recent_ff[2]};

   // Next state and result of the word at the queue head.
   always_comb begin
      pos_in    = pos_ff;
      recent_in = recent_ff;
      hdr_in    = hdr_ff;
      sum_in    = sum_ff;
      ovf_in    = ovf_ff;
      uptime_in = uptime_ff;
      since_in  = since_ff;
      ev_in     = EV_NONE;
      len_in    = 8'd0;
      addr_in   = 8'd0;
      cmd_in    = 8'd0;
      arg_in    = 8'd0;
      rxsum_in  = 16'd0;

      if (head.item.is_tick) begin
         if (uptime_ff < startup_hold_ff) begin
            uptime_in = uptime_ff + 16'd1;
         end
         if (since_ff < COUNTER_MAX) begin
            since_in = since_ff + 16'd1;
         end
      end else begin
         if (close) begin
            len_in = (32'(flen) > 32'(LENGTH_MAX)) ? LENGTH_MAX : 8'(flen);
            if (32'(flen) > 32'd1) begin
               addr_in = hdr_ff[0];
            end
            if (32'(flen) > 32'd2) begin
               cmd_in = hdr_ff[1];
            end
            if (32'(flen) > 32'd3) begin
               arg_in = hdr_ff[2];
            end
            if (32'(flen) < 32'd4) begin
               ev_in = EV_RUNT;
            end else begin
               rxsum_in = frame_sum;
               if (ovf_ff || ((sum_ff ^ SUM_INVERT) != frame_sum)) begin
                  ev_in = EV_BAD_SUM;
               end else if (hdr_ff[0] == own_address_ff) begin
                  ev_in = EV_OWN_ECHO;
               end else begin
                  ev_in    = EV_VALID;
                  since_in = 16'd0;
               end
            end
            pos_in = '0;
            sum_in = 16'd0;
            ovf_in = 1'b0;
         end else begin
            // Capture the address, command and argument bytes.
            if (pos_ff == PW'(1)) begin
               hdr_in[0] = head.item.rx_byte;
            end
            if (pos_ff == PW'(2)) begin
               hdr_in[1] = head.item.rx_byte;
            end
            if (pos_ff == PW'(3)) begin
               hdr_in[2] = head.item.rx_byte;
            end
            // The sum trails the stream by three bytes.
            if (pos_ff >= PW'(3)) begin
               sum_in = sum_ext[15:0];
               if (sum_ext[16]) begin
                  ovf_in = 1'b1;
               end
            end
            if (pos_ff >= POS_LAST) begin
               pos_in = '0;
               sum_in = 16'd0;
               ovf_in = 1'b0;
            end else begin
               pos_in = pos_ff + PW'(1);
            end
         end
         recent_in[2] = recent_ff[1];
         recent_in[1] = recent_ff[0];
         recent_in[0] = head.item.rx_byte;
      end

      conn_in = (uptime_in >= startup_hold_ff) && (since_in < link_timeout_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         recent_ff    <= '{8'd0, 8'd0, 8'd0};
         hdr_ff       <= '{8'd0, 8'd0, 8'd0};
         sum_ff       <= 16'd0;
         ovf_ff       <= 1'b0;
         uptime_ff    <= 16'd0;
         since_ff     <= LINK_TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            pos_ff    <= pos_in;
            recent_ff <= recent_in;
            hdr_ff    <= hdr_in;
            sum_ff    <= sum_in;
            ovf_ff    <= ovf_in;
            uptime_ff <= uptime_in;
            since_ff  <= since_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      if (pop) begin
         ev_ff    <= ev_in;
         len_ff   <= len_in;
         addr_ff  <= addr_in;
         cmd_ff   <= cmd_in;
         arg_ff   <= arg_in;
         rxsum_ff <= rxsum_in;
         conn_ff  <= conn_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.event_res         = ev_ff;
   assign rsp_chan.frame_length      = len_ff;
   assign rsp_chan.address           = addr_ff;
   assign rsp_chan.command           = cmd_ff;
   assign rsp_chan.argument          = arg_ff;
   assign rsp_chan.received_checksum = rxsum_ff;
   assign rsp_chan.connected         = conn_ff;

endmodule

@@ hw/rtl/serial_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// serial_frame_receiver_top
// Header-delimited serial frame receiver with inverted-sum checksum.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle (a received byte or a millisecond
// tick) and returns exactly one result word per input word, in order. An
// accepted word goes into a two-entry queue in the front end; the back end
// executes one queued word per cycle into a result register, so without a
// stall the result is valid right after the clock edge that follows the
// accepting edge, and the sustained rate is one word per cycle as long as the
// result side keeps up. The configuration port is always ready and takes
// effect on the next executed word.
module serial_frame_receiver_top
   import sfr_pkg::*;
#(
   parameter int MAX_POSITION = 256
)
(
   input  logic      clock,
   input  logic      reset,
   sfr_req_if.sink   req_chan,
   sfr_rsp_if.source rsp_chan,
   sfr_csr_if.sink   csr_chan
);

   queue_head_type head;
   logic           pop;

   // Front end: accept, classify and queue.
   sfr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head     (head),
      .pop      (pop)
   );

   // Back end: frame tracking and results.
   sfr_back #(
      .MAX_POSITION (MAX_POSITION)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ hw/rtl/sfr_checker.sv @@
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the serial frame receiver result channel.
// ----------------------------------------------------------------------------
module sfr_checker
   import sfr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  event_res,
   input logic [7:0]  frame_length,
   input logic [7:0]  address,
   input logic [7:0]  command,
   input logic [7:0]  argument,
   input logic [15:0] received_checksum
);

   // A stalled result stays and holds its event.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_res))
      else $error("stalled result changed");

   // No result is shown right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A word without a frame event carries only the link flag.
   a_none_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_res == EV_NONE |->
      frame_length == 8'd0 && address == 8'd0 && command == 8'd0 &&
      argument == 8'd0 && received_checksum == 16'd0)
      else $error("fields set without an event");

   // A runt is shorter than four bytes and carries no checksum.
   a_runt_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_res == EV_RUNT |->
      frame_length < 8'd4 && received_checksum == 16'd0 && argument == 8'd0)
      else $error("runt result inconsistent");

endmodule

bind serial_frame_receiver_top sfr_checker u_sfr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .event_res         (rsp_chan.event_res),
   .frame_length      (rsp_chan.frame_length),
   .address           (rsp_chan.address),
   .command           (rsp_chan.command),
   .argument          (rsp_chan.argument),
   .received_checksum (rsp_chan.received_checksum)
);
